>>> rtl/core/lphs_pkg.sv
`timescale 1ns / 1ps
package lphs_pkg;

	localparam int KEY_W  = 31;
	localparam int OP_W   = 2;
	localparam int MARK_W = 2;
	localparam int STAT_W = 2;
	localparam int SLOT_W = 4;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

	localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
	localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
	localparam logic [MARK_W-1:0] MARK_DEAD  = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic              clr;
		logic              load;
		logic              mod_step;
		logic              rd;
		logic              advance;
		logic              wr;
		logic [MARK_W-1:0] wr_mark;
		logic              res_load;
		logic [STAT_W-1:0] res_status;
		logic              res_found;
		logic              res_slot;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic              clr_last;
		logic              mod_last;
		logic              probe_last;
		logic [OP_W-1:0]   op;
		logic [MARK_W-1:0] mark;
		logic              key_hit;
	} stat_t;

endpackage

>>> rtl/core/lphs_ram.sv
`timescale 1ns / 1ps
module lphs_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/lphs_dp.sv
`timescale 1ns / 1ps
module lphs_dp #(
	parameter int TABLE_SIZE = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lphs_pkg::cmd_t               cmd,
	output lphs_pkg::stat_t              stat,
	input  logic [lphs_pkg::OP_W-1:0]    opcode,
	input  logic [lphs_pkg::KEY_W-1:0]   key,
	output logic [lphs_pkg::STAT_W-1:0]  status,
	output logic                         found,
	output logic [lphs_pkg::SLOT_W-1:0]  slot
);
	import lphs_pkg::*;

	localparam int IDX_W  = $clog2(TABLE_SIZE);
	localparam int WORD_W = MARK_W + KEY_W;
	localparam int PROD_W = KEY_W + 32;
	// floor(2^32 / TABLE_SIZE): the quotient estimate is exact or one low
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(TABLE_SIZE));

	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  idx_next;
	logic [IDX_W-1:0]  n_q;
	logic [1:0]        mod_cnt_q;
	logic [KEY_W-1:0]  key_q;
	logic [OP_W-1:0]   op_q;
	logic [PROD_W-1:0] prod;
	logic [KEY_W-1:0]  q_s1;
	logic [KEY_W-1:0]  qm;
	logic [KEY_W-1:0]  diff;
	logic [IDX_W:0]    rem_s2;
	logic [IDX_W:0]    rem_red;
	logic              ram_we;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;
	logic [31:0]       idx_ext;

	assign idx_next = (idx_q == IDX_W'(TABLE_SIZE - 1)) ? '0 : idx_q + 1'b1;

	// home slot: reciprocal multiply, multiply-subtract, then one correcting compare
	assign prod    = PROD_W'(key_q) * PROD_W'(RECIP);
	assign qm      = q_s1 * KEY_W'(TABLE_SIZE);
	assign diff    = key_q - qm;
	assign rem_red = (rem_s2 >= (IDX_W+1)'(TABLE_SIZE)) ?
		rem_s2 - (IDX_W+1)'(TABLE_SIZE) : rem_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
		end else if (cmd.mod_step && stat.mod_last) begin
			idx_q <= rem_red[IDX_W-1:0];
		end else if (cmd.clr || cmd.advance) begin
			idx_q <= idx_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q     <= key;
			op_q      <= opcode;
			mod_cnt_q <= '0;
			n_q       <= '0;
		end else begin
			if (cmd.mod_step) begin
				mod_cnt_q <= mod_cnt_q + 1'b1;
				q_s1      <= prod[PROD_W-1:32];
				rem_s2    <= diff[IDX_W:0];
			end
			if (cmd.advance) begin
				n_q <= n_q + 1'b1;
			end
		end
	end

	assign ram_we    = cmd.clr | cmd.wr;
	assign ram_wdata = cmd.clr ? {MARK_EMPTY, {KEY_W{1'b0}}} : {cmd.wr_mark, key_q};

	lphs_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TABLE_SIZE)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (ram_wdata),
		.re    (cmd.rd),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign stat.clr_last   = (idx_q == IDX_W'(TABLE_SIZE - 1));
	assign stat.mod_last   = (mod_cnt_q == 2'd2);
	assign stat.probe_last = (n_q == IDX_W'(TABLE_SIZE - 1));
	assign stat.op         = op_q;
	assign stat.mark       = ram_rdata[WORD_W-1:KEY_W];
	assign stat.key_hit    = (ram_rdata[KEY_W-1:0] == key_q);

	assign idx_ext = 32'(idx_q);

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status <= cmd.res_status;
			found  <= cmd.res_found;
			slot   <= cmd.res_slot ? idx_ext[SLOT_W-1:0] : '0;
		end
	end

endmodule

>>> rtl/core/lphs_ctrl.sv
`timescale 1ns / 1ps
module lphs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	output lphs_pkg::cmd_t  cmd,
	input  lphs_pkg::stat_t stat
);
	import lphs_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_RD,
		S_CHK,
		S_RESP
	} state_t;

	state_t            state_q;
	state_t            state_d;
	logic              res_set;
	logic [STAT_W-1:0] res_status_d;
	logic              res_found_d;
	logic              res_slot_d;
	logic [STAT_W-1:0] res_status_q;
	logic              res_found_q;
	logic              res_slot_q;
	logic              out_free;

	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid || !out_stall;

	always_comb begin
		cmd          = '0;
		state_d      = state_q;
		res_set      = 1'b0;
		res_status_d = ST_NOTFOUND;
		res_found_d  = 1'b0;
		res_slot_d   = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MOD;
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (stat.mod_last) begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (stat.op == OP_INSERT) begin
					if (stat.mark != MARK_USED) begin
						cmd.wr       = 1'b1;
						cmd.wr_mark  = MARK_USED;
						res_set      = 1'b1;
						res_status_d = ST_OK;
						res_slot_d   = 1'b1;
					end else if (stat.probe_last) begin
						res_set      = 1'b1;
						res_status_d = ST_FULL;
					end
				end else begin
					// delete, lookup and the spare opcode skip tombstones, stop at an empty slot
					if (stat.mark == MARK_EMPTY) begin
						res_set = 1'b1;
					end else if (stat.mark == MARK_USED && stat.key_hit) begin
						cmd.wr       = (stat.op == OP_DELETE);
						cmd.wr_mark  = MARK_DEAD;
						res_set      = 1'b1;
						res_status_d = ST_OK;
						res_found_d  = 1'b1;
						res_slot_d   = 1'b1;
					end else if (stat.probe_last) begin
						res_set = 1'b1;
					end
				end
				if (res_set) begin
					state_d = S_RESP;
				end else begin
					cmd.advance = 1'b1;
					state_d     = S_RD;
				end
			end
			S_RESP: begin
				if (out_free) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = res_status_q;
					cmd.res_found  = res_found_q;
					cmd.res_slot   = res_slot_q;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			out_valid    <= 1'b0;
			res_status_q <= ST_OK;
			res_found_q  <= 1'b0;
			res_slot_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			if (res_set) begin
				res_status_q <= res_status_d;
				res_found_q  <= res_found_d;
				res_slot_q   <= res_slot_d;
			end
		end
	end

endmodule

>>> rtl/core/linear_probe_hash_set.sv
`timescale 1ns / 1ps
// channel  direction  handshake              fields
// in       sink       in_valid / in_stall    opcode, key
// out      source     out_valid / out_stall  status, found, slot
//
// home slot from a reciprocal multiply, a multiply-subtract and a correcting compare
// each probed slot takes a table ram read, then a check and optional write
// after reset a clearing pass marks every slot empty, in_stall high
// a result waits in the output register while the next item is taken in
// a result still stalled at the output holds the next one in the response state
module linear_probe_hash_set #(
	parameter int TABLE_SIZE = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [lphs_pkg::OP_W-1:0]   opcode,
	input  logic [lphs_pkg::KEY_W-1:0]  key,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [lphs_pkg::STAT_W-1:0] status,
	output logic                        found,
	output logic [lphs_pkg::SLOT_W-1:0] slot
);
	import lphs_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	lphs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	lphs_dp #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.opcode (opcode),
		.key    (key),
		.status (status),
		.found  (found),
		.slot   (slot)
	);

	// one item at a time: a transfer in closes the input until the result is loaded
	a_in_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again right after a transfer");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |-> (status == ST_OK))
		else $error("found set with a failing status");

	a_fail_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (slot == '0 && !found))
		else $error("failed operation reports a slot");

	// the table ram is only written while the input is closed
	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr || cmd.clr) |-> in_stall)
		else $error("table written while idle");

endmodule

>>> tb/hash_set_checker.sv
`timescale 1ns / 1ps
module hash_set_checker #(
	parameter int TABLE_SIZE = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [lphs_pkg::OP_W-1:0]   opcode,
	input  logic [lphs_pkg::KEY_W-1:0]  key,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [lphs_pkg::STAT_W-1:0] status,
	input  logic                        found,
	input  logic [lphs_pkg::SLOT_W-1:0] slot,
	output int                          fail_count,
	output int                          pending_count
);
	import lphs_pkg::*;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              found;
		logic [SLOT_W-1:0] slot;
	} probe_result_t;

	logic [MARK_W-1:0] slot_mark_copy [TABLE_SIZE];
	logic [KEY_W-1:0]  slot_key_copy  [TABLE_SIZE];
	probe_result_t     awaited_results [$];
	int                result_index;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: result %0d: %s", $time, result_index, msg);
		fail_count++;
	endtask

	// applies one operation to the shadow table and returns what the block should answer
	function automatic probe_result_t table_update(input logic [OP_W-1:0] op,
			input logic [KEY_W-1:0] k);
		probe_result_t r;
		int            s;
		bit            done;
		r.status = (op == OP_INSERT) ? ST_FULL : ST_NOTFOUND;
		r.found  = 1'b0;
		r.slot   = '0;
		s        = int'(k % TABLE_SIZE);
		done     = 1'b0;
		for (int n = 0; n < TABLE_SIZE && !done; n++) begin
			if (op == OP_INSERT) begin
				// no duplicate check, tombstones are reused
				if (slot_mark_copy[s] != MARK_USED) begin
					slot_key_copy[s]  = k;
					slot_mark_copy[s] = MARK_USED;
					r.status          = ST_OK;
					r.slot            = SLOT_W'(s);
					done              = 1'b1;
				end
			end else if (slot_mark_copy[s] == MARK_EMPTY) begin
				done = 1'b1;
			end else if (slot_mark_copy[s] == MARK_USED && slot_key_copy[s] == k) begin
				// delete turns the slot into a tombstone, lookup and spare opcode leave it
				if (op == OP_DELETE)
					slot_mark_copy[s] = MARK_DEAD;
				r.status = ST_OK;
				r.found  = 1'b1;
				r.slot   = SLOT_W'(s);
				done     = 1'b1;
			end
			s = (s + 1) % TABLE_SIZE;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		probe_result_t got;
		probe_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SIZE; i++)
				slot_mark_copy[i] = MARK_EMPTY;
			awaited_results.delete();
			pending_count <= 0;
		end else begin
			// pop before push: a result never belongs to the transfer of the same edge
			if (out_valid && !out_stall) begin
				got.status = status;
				got.found  = found;
				got.slot   = slot;
				if (awaited_results.size() == 0) begin
					report_mismatch("result with no transfer awaiting it");
				end else begin
					want = awaited_results.pop_front();
					if (got.status !== want.status)
						report_mismatch($sformatf("status expected %0d got %0d",
							want.status, got.status));
					if (got.found !== want.found)
						report_mismatch($sformatf("found expected %0d got %0d",
							want.found, got.found));
					if (got.slot !== want.slot)
						report_mismatch($sformatf("slot expected %0d got %0d",
							want.slot, got.slot));
				end
				result_index++;
			end
			if (in_valid && !in_stall)
				awaited_results.push_back(table_update(opcode, key));
			pending_count <= awaited_results.size();
		end
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import lphs_pkg::*;

	localparam int TABLE_SIZE   = 16;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 120;
	localparam int PHASES       = 9;
	localparam int PHASE_ITEMS  = 150;
	localparam int POOL_SIZE    = 24;

	localparam logic [OP_W-1:0]  OP_SPARE = 2'd3;
	localparam logic [KEY_W-1:0] KEY_MAX  = '1;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                out_stall = 1'b0;
	logic [OP_W-1:0]     opcode    = OP_INSERT;
	logic [KEY_W-1:0]    key       = '0;
	logic                in_stall;
	logic                out_valid;
	logic [STAT_W-1:0]   status;
	logic                found;
	logic [SLOT_W-1:0]   slot;
	int                  fail_count;
	int                  pending_count;
	int                  idle_cycles;
	bit                  quiet;
	logic [KEY_W-1:0]    key_pool [POOL_SIZE];

	linear_probe_hash_set #(.TABLE_SIZE(TABLE_SIZE)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.key       (key),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.found     (found),
		.slot      (slot)
	);

	hash_set_checker #(.TABLE_SIZE(TABLE_SIZE)) result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.key           (key),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.found         (found),
		.slot          (slot),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int draw_gap();
		return quiet ? 0 : $urandom_range(6);
	endfunction

	task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		key      <= k;
		do @(posedge clk); while (in_stall);
	endtask

	// hold the input off until every outstanding result has been taken
	task automatic wait_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
	endtask

	// result side: one drawn stall per result
	initial begin
		int gap;
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// ends the run when no transfer happens on either channel for too long
	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int               n;
		int               r;
		int               ins_pct;
		int               del_pct;
		int               home_base;
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] k;
		quiet = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// empty table, key zero must not look like a free slot
		send_item(OP_LOOKUP, '0);
		send_item(OP_INSERT, '0);
		send_item(OP_INSERT, KEY_W'(16));
		send_item(OP_INSERT, KEY_MAX);
		// home slot 15 taken, probe wraps round to slot 2
		send_item(OP_INSERT, KEY_W'(31));
		send_item(OP_DELETE, '0);
		// lookup must walk past the tombstone in slot 0
		send_item(OP_LOOKUP, KEY_W'(31));
		// missing key behind a tombstone: no change to the table
		send_item(OP_DELETE, KEY_W'(48));
		send_item(OP_LOOKUP, '0);
		send_item(OP_INSERT, KEY_W'(32));
		send_item(OP_SPARE, KEY_W'(16));
		// duplicate insert, then delete takes the first copy only
		send_item(OP_INSERT, KEY_W'(16));
		send_item(OP_DELETE, KEY_W'(16));
		send_item(OP_LOOKUP, KEY_W'(16));
		for (n = 0; n < 12; n++)
			send_item(OP_INSERT, KEY_W'($urandom));
		// full table: insert fails, missing key probes every slot
		send_item(OP_INSERT, KEY_W'($urandom));
		send_item(OP_LOOKUP, KEY_W'(5));
		send_item(OP_DELETE, KEY_MAX - KEY_W'(1));
		wait_results();

		for (int phase = 0; phase < PHASES; phase++) begin
			quiet     = ($urandom_range(3) == 0);
			ins_pct   = $urandom_range(20, 60);
			del_pct   = $urandom_range(10, 90 - ins_pct);
			home_base = $urandom_range(TABLE_SIZE - 1);
			// small key set crowded onto a few neighboring home slots
			for (n = 0; n < POOL_SIZE; n++) begin
				k      = KEY_W'($urandom);
				k[3:0] = 4'(home_base + $urandom_range(5));
				key_pool[n] = k;
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(99);
				if (r < ins_pct)
					op = OP_INSERT;
				else if (r < ins_pct + del_pct)
					op = OP_DELETE;
				else if (r < 97)
					op = OP_LOOKUP;
				else
					op = OP_SPARE;
				if ($urandom_range(19) == 0)
					k = KEY_W'($urandom);
				else
					k = key_pool[$urandom_range(POOL_SIZE - 1)];
				send_item(op, k);
			end
			wait_results();
		end

		quiet = 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/lphs_pkg.sv
rtl/core/lphs_ram.sv
rtl/core/lphs_dp.sv
rtl/core/lphs_ctrl.sv
rtl/core/linear_probe_hash_set.sv
tb/hash_set_checker.sv
tb/testbench.sv
